### hdl/fnmb_pkg.sv
// Package for the four-neighbor mean blur core: geometry limits, pixel types,
// configuration register codes and line-buffer request/read structs.
// No dependencies.
`timescale 1ns / 1ps

package fnmb_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned MinDim     = 3;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 13;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumLanes   = 3;
  localparam int unsigned WidthRst   = 640;
  localparam int unsigned HeightRst  = 480;

  typedef logic [ChanW-1:0] chan_t;

  // blue sits in the low byte
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef enum logic {
    CfgImageWidth,
    CfgImageHeight
  } cfg_reg_e;

  typedef struct packed {
    logic            accept;
    logic [ColW-1:0] col;
    pixel_t          px;
  } lb_req_t;

  typedef struct packed {
    pixel_t up;
    pixel_t left;
    pixel_t center;
    pixel_t right;
  } lb_rd_t;

endpackage

### hdl/fnmb_if.sv
// Stream interfaces of the blur core: input pixel channel and result channel.
// Depends on nothing; payload widths are the fixed 8-bit channels.
`timescale 1ns / 1ps

interface fnmb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;

  modport source (output valid, output in_blue, output in_green, output in_red,
                  input ready);
  modport sink   (input valid, input in_blue, input in_green, input in_red,
                  output ready);
endinterface

interface fnmb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output run_last, output frame_end, input ready);
  modport sink   (input valid, input out_blue, input out_green, input out_red,
                  input run_last, input frame_end, output ready);
endinterface

### hdl/fnmb_line_buf.sv
// Two line stores (row r-1 and row r-2) with registered reads and a
// registered write-behind. Depends on fnmb_pkg.
`timescale 1ns / 1ps

module fnmb_line_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fnmb_pkg::lb_req_t req_i,
  output fnmb_pkg::lb_rd_t  rd_o
);
  import fnmb_pkg::*;

  pixel_t older_mem [MaxWidth];
  pixel_t prev_mem  [MaxWidth];

  pixel_t          up_q, left_q, center_q, right_q;
  pixel_t          wr_px_q;
  logic [ColW-1:0] wr_col_q;
  logic            wr_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= req_i.accept;
    end
  end

  // The write of a beat lands in the cycle after its read. The next beat reads
  // columns c+1 and c+2 (or 0 and 1 after a wrap), never the column written.
  always_ff @(posedge clk_i) begin
    if (req_i.accept) begin
      up_q     <= older_mem[req_i.col];
      center_q <= prev_mem[req_i.col];
      right_q  <= prev_mem[req_i.col + ColW'(1)];
      left_q   <= center_q;
      wr_col_q <= req_i.col;
      wr_px_q  <= req_i.px;
    end
    if (wr_pend_q) begin
      older_mem[wr_col_q] <= center_q;
      prev_mem[wr_col_q]  <= wr_px_q;
    end
  end

  assign rd_o.up     = up_q;
  assign rd_o.left   = left_q;
  assign rd_o.center = center_q;
  assign rd_o.right  = right_q;

endmodule

### hdl/fnmb_lane.sv
// One channel lane: floor of the mean of four 8-bit neighbors.
// Depends on fnmb_pkg.
`timescale 1ns / 1ps

module fnmb_lane (
  input  fnmb_pkg::chan_t up_i,
  input  fnmb_pkg::chan_t left_i,
  input  fnmb_pkg::chan_t right_i,
  input  fnmb_pkg::chan_t down_i,
  output fnmb_pkg::chan_t mean_o
);
  import fnmb_pkg::*;

  logic [ChanW+1:0] sum;

  assign sum    = (ChanW+2)'(up_i) + (ChanW+2)'(left_i)
                + (ChanW+2)'(right_i) + (ChanW+2)'(down_i);
  assign mean_o = sum[ChanW+1:2];

endmodule

### hdl/four_neighbor_mean_blur_core.sv
// Four-neighbor mean blur, 24-bit BGR raster stream; a row is output as the next comes in.
// Channels: in_ch (pixel beats in), out_ch (result beats out), each
// valid/ready; a beat moves when both are high. Config: cfg_we_i writes
// cfg_data_i into register cfg_idx_i (0 image_width, 1 image_height) at the
// clock edge; write only while the block is idle.
// A result passes from the stage-1 registers into the output register. The input
// takes one pixel per cycle while out_ch is not stalled; in the last row each
// pixel yields two result beats, so the input takes a new pixel there only once
// both have gone to the single output register. Row 0 yields nothing.
// Three byte lanes compute the means in parallel; the merge stage picks
// the mean or the pass-through pixel and packs the result beat.
// Reset: counters go to zero, width/height to 640/480, both pipeline
// stages empty; line stores are not cleared and hold stale data until the
// first two rows of a frame rewrite them.
// Receiver stall: the output register holds its beat; the input stage
// keeps one pixel and then drops in_ch.ready until the result drains.
// Depends on fnmb_pkg, fnmb_if, fnmb_line_buf and fnmb_lane.
`timescale 1ns / 1ps

module four_neighbor_mean_blur_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fnmb_pix_if.sink                        in_ch,
  fnmb_res_if.source                      out_ch,
  input  logic                            cfg_we_i,
  input  fnmb_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [fnmb_pkg::CfgDataW-1:0]   cfg_data_i
);
  import fnmb_pkg::*;

  // configuration
  logic [CfgWidthW-1:0]  cfg_w_q;
  logic [CfgHeightW-1:0] cfg_h_q;
  logic [CfgWidthW-1:0]  w_use;
  logic [CfgHeightW-1:0] h_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CfgWidthW'(WidthRst);
      cfg_h_q <= CfgHeightW'(HeightRst);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgImageWidth:  cfg_w_q <= cfg_data_i[CfgWidthW-1:0];
        CfgImageHeight: cfg_h_q <= cfg_data_i[CfgHeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (cfg_w_q < CfgWidthW'(MinDim)) w_use = CfgWidthW'(MinDim);
    else if (cfg_w_q > CfgWidthW'(MaxWidth))   w_use = CfgWidthW'(MaxWidth);
    else                                       w_use = cfg_w_q;
    priority if (cfg_h_q < CfgHeightW'(MinDim)) h_use = CfgHeightW'(MinDim);
    else if (cfg_h_q > CfgHeightW'(MaxHeight))  h_use = CfgHeightW'(MaxHeight);
    else                                        h_use = cfg_h_q;
  end

  // position counters and per-beat classification
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            last_col, last_row, interior, emit;
  logic            accept;

  assign last_col = CfgWidthW'(col_q) >= (w_use - CfgWidthW'(1));
  assign last_row = CfgHeightW'(row_q) >= (h_use - CfgHeightW'(1));
  assign emit     = (row_q != '0);
  assign interior = (row_q >= RowW'(2)) && (CfgHeightW'(row_q) <= (h_use - CfgHeightW'(1)))
                  && (col_q != '0) && !last_col;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: pixel with line-store reads
  logic   s1_valid_q, phase_q;
  logic   s1_emit_q, s1_last_row_q, s1_last_col_q, s1_interior_q;
  pixel_t s1_px_q;
  pixel_t in_px;
  logic   out_free, s1_take, s1_done;

  assign in_px.blue  = in_ch.in_blue;
  assign in_px.green = in_ch.in_green;
  assign in_px.red   = in_ch.in_red;

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign s1_take     = s1_valid_q && s1_emit_q && out_free;
  assign s1_done     = s1_valid_q && (!s1_emit_q || (out_free && (!s1_last_row_q || phase_q)));
  assign in_ch.ready = !s1_valid_q || s1_done;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= 1'b0;
    end else begin
      if (accept)       s1_valid_q <= 1'b1;
      else if (s1_done) s1_valid_q <= 1'b0;
      if (accept)       phase_q <= 1'b0;
      else if (s1_take) phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q       <= in_px;
      s1_emit_q     <= emit;
      s1_last_row_q <= last_row;
      s1_last_col_q <= last_col;
      s1_interior_q <= interior;
    end
  end

  lb_req_t lb_req;
  lb_rd_t  lb_rd;

  assign lb_req.accept = accept;
  assign lb_req.col    = col_q;
  assign lb_req.px     = in_px;

  fnmb_line_buf u_line_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lb_req),
    .rd_o   (lb_rd)
  );

  // byte lanes
  pixel_t mean_px;

  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    fnmb_lane u_lane (
      .up_i    (lb_rd.up[k*ChanW +: ChanW]),
      .left_i  (lb_rd.left[k*ChanW +: ChanW]),
      .right_i (lb_rd.right[k*ChanW +: ChanW]),
      .down_i  (s1_px_q[k*ChanW +: ChanW]),
      .mean_o  (mean_px[k*ChanW +: ChanW])
    );
  end

  // merge: first beat is the row above (filtered or border), second beat of
  // a last-row pixel is the pixel itself
  pixel_t res_px;
  logic   res_last, res_fend;

  always_comb begin
    if (phase_q) begin
      res_px   = s1_px_q;
      res_last = 1'b1;
      res_fend = s1_last_col_q;
    end else begin
      res_px   = s1_interior_q ? mean_px : lb_rd.center;
      res_last = !s1_last_row_q;
      res_fend = 1'b0;
    end
  end

  logic   out_valid_q;
  pixel_t out_px_q;
  logic   out_last_q, out_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      out_px_q   <= res_px;
      out_last_q <= res_last;
      out_fend_q <= res_fend;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.out_blue  = out_px_q.blue;
  assign out_ch.out_green = out_px_q.green;
  assign out_ch.out_red   = out_px_q.red;
  assign out_ch.run_last  = out_last_q;
  assign out_ch.frame_end = out_fend_q;

endmodule

### hdl/fnmb_checker.sv
// Port-level checks for four_neighbor_mean_blur_core, attached by bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module fnmb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_blue_i,
  input logic [7:0] out_green_i,
  input logic [7:0] out_red_i,
  input logic       run_last_i,
  input logic       frame_end_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_blue_i) && $stable(out_green_i)
      && $stable(out_red_i) && $stable(run_last_i) && $stable(frame_end_i))
    else $error("result payload changed while stalled");

  a_fend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> run_last_i)
    else $error("frame end on a beat that is not the last of its pixel");

  // in the last row the pixel itself follows its row-above beat at once
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !run_last_i |=> out_valid_i && run_last_i)
    else $error("second beat of a last-row pixel not presented next cycle");

endmodule

bind four_neighbor_mean_blur_core fnmb_checker u_fnmb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_blue_i  (out_ch.out_blue),
  .out_green_i (out_ch.out_green),
  .out_red_i   (out_ch.out_red),
  .run_last_i  (out_ch.run_last),
  .frame_end_i (out_ch.frame_end)
);
